@@ rtl/pdt_pkg.sv @@
// Shared types and constants for the XOR-distance peer table.
// Used by the scan cells, the top level and the port checker.
package pdt_pkg;

	localparam int IdBitsDefault = 64;
	localparam int TableSlotsDefault = 64;
	localparam int IdW = 64;

	localparam logic [2:0] CMD_ADD     = 3'd0;
	localparam logic [2:0] CMD_HAS     = 3'd1;
	localparam logic [2:0] CMD_REMOVE  = 3'd2;
	localparam logic [2:0] CMD_CLOSEST = 3'd3;
	localparam logic [2:0] CMD_LEVEL   = 3'd4;
	localparam logic [2:0] CMD_TARGET  = 3'd5;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NONE = 2'd2;

	localparam logic [2:0] REG_LOCAL_ID = 3'd0;

	// Search token handed from cell to cell along the table.
	typedef struct packed {
		logic           vld;
		logic [2:0]     cmd;
		logic [IdW-1:0] pid;
		logic [IdW-1:0] exc;
		logic           hit;
		logic [IdW-1:0] best;
		logic [IdW-1:0] best_d;
	} tok_t;

endpackage

@@ rtl/pdt_cell.sv @@
// One table slot: holds an id and its valid bit, updates the passing token.
// Depends on pdt_pkg.
module pdt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  pdt_pkg::tok_t tok_in,
	output pdt_pkg::tok_t tok_out
);

	logic [pdt_pkg::IdW-1:0] id_q;
	logic                    valid_q;
	pdt_pkg::tok_t           tok_s1;
	pdt_pkg::tok_t           nxt;
	logic                    wr_en;
	logic                    clr_en;
	logic                    match;
	logic                    qual;
	logic [pdt_pkg::IdW-1:0] gap;

	assign match = valid_q && (id_q == tok_in.pid);
	assign qual  = valid_q && (id_q != '0) && (id_q != tok_in.exc);
	assign gap   = id_q ^ tok_in.pid;

	always_comb begin
		nxt    = tok_in;
		wr_en  = 1'b0;
		clr_en = 1'b0;
		if (tok_in.vld) begin
			case (tok_in.cmd)
				pdt_pkg::CMD_ADD: begin
					if (!tok_in.hit && !valid_q) begin
						nxt.hit = 1'b1;
						wr_en   = 1'b1;
					end
				end
				pdt_pkg::CMD_HAS: begin
					if (match) begin
						nxt.hit = 1'b1;
					end
				end
				pdt_pkg::CMD_REMOVE: begin
					if (!tok_in.hit && match) begin
						nxt.hit = 1'b1;
						clr_en  = 1'b1;
					end
				end
				pdt_pkg::CMD_CLOSEST: begin
					if (qual && (!tok_in.hit || gap < tok_in.best_d)) begin
						nxt.hit    = 1'b1;
						nxt.best   = id_q;
						nxt.best_d = gap;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_s1  <= '0;
		end else begin
			tok_s1 <= nxt;
			if (wr_en) begin
				valid_q <= 1'b1;
			end else if (clr_en) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q <= tok_in.pid;
		end
	end

	assign tok_out = tok_s1;

endmodule

@@ rtl/xor_distance_peer_table.sv @@
// XOR-distance peer table: top level with the command sequencer and result register.
// Depends on pdt_pkg and pdt_cell.
//
// One command item enters on the s_ channel (command in s_tuser), one result
// item leaves on the m_ channel (status in m_tuser). local_id is written over
// the APB port at address 0; the user must do so only while the block is idle (unchecked).
// Add, has, remove and closest send a token down a row of TABLE_SLOTS cells,
// one cell per cycle. Level walks the distance from its top bit, one bit per
// cycle. Target, level of equal ids and unused codes go from acceptance
// straight to the done state.
// The block works on one item at a time; s_tready is high whenever no item is
// in progress, even if the previous result still waits in the output register.
// If the receiver stalls, a finished result waits in an internal register until
// the output register frees up.
// Reset empties the table (all valid bits cleared), clears local_id and drops
// any item in flight.
module xor_distance_peer_table #(
	parameter int ID_BITS = pdt_pkg::IdBitsDefault,
	parameter int TABLE_SLOTS = pdt_pkg::TableSlotsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [63:0] peer_id, [127:64] except_id, [128] include_local, [135:129] level_in
	input  logic [135:0] s_tdata,
	// [2:0] command
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] result_id, [64] is_local, [71:65] level_out
	output logic [71:0]  m_tdata,
	// [1:0] status
	output logic [1:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	localparam int BW = $clog2(ID_BITS);
	localparam logic [63:0] IdMask = (ID_BITS >= 64) ? '1 : ((64'd1 << ID_BITS) - 64'd1);
	localparam logic [6:0] TopLvl = 7'(2 * ID_BITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_LVL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t        state_q;
	logic [63:0]   local_id_q;
	logic          inc_q;
	logic [63:0]   d_q;
	logic [BW-1:0] b_q;
	logic [1:0]    res_status_q;
	logic [63:0]   res_id_q;
	logic          res_loc_q;
	logic [6:0]    res_lvl_q;
	logic          m_tvalid_q;
	logic [71:0]   m_tdata_q;
	logic [1:0]    m_tuser_q;

	pdt_pkg::tok_t chain [TABLE_SLOTS+1];

	logic        accept;
	logic [2:0]  cmd;
	logic [63:0] pid;
	logic [63:0] exc;
	logic [63:0] loc;
	logic [6:0]  lvl_in;
	logic [63:0] d_in;
	logic [6:0]  v;
	logic [5:0]  tb;
	logic [63:0] tdist;
	logic [6:0]  lvl;
	logic        out_free;
	pdt_pkg::tok_t tok_end;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cmd      = s_tuser;
	assign pid      = s_tdata[63:0] & IdMask;
	assign exc      = s_tdata[127:64] & IdMask;
	assign lvl_in   = s_tdata[135:129];
	assign loc      = local_id_q & IdMask;
	assign d_in     = pid ^ loc;
	assign out_free = !m_tvalid_q || m_tready;
	assign tok_end  = chain[TABLE_SLOTS];

	// Target distance: bit v/2, and the bit below it for odd v above 1.
	assign v  = TopLvl - lvl_in;
	assign tb = v[6:1];
	always_comb begin
		tdist = 64'd1 << tb;
		if (v[0] && (tb != 6'd0)) begin
			tdist = tdist | (64'd1 << (tb - 6'd1));
		end
	end

	assign lvl = {b_q, 1'b0} + 7'(d_q[ID_BITS-2]);

	assign chain[0] = '{
		vld:    accept && (cmd <= pdt_pkg::CMD_CLOSEST),
		cmd:    cmd,
		pid:    pid,
		exc:    exc,
		hit:    1'b0,
		best:   '0,
		best_d: '0
	};

	for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
		pdt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[g]),
			.tok_out(chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			local_id_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && (paddr == pdt_pkg::REG_LOCAL_ID)) begin
				local_id_q <= pwdata;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd <= pdt_pkg::CMD_CLOSEST) begin
							state_q <= ST_SCAN;
						end else if (cmd == pdt_pkg::CMD_LEVEL && d_in != '0) begin
							state_q <= ST_LVL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (tok_end.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_LVL: begin
					if (d_q[ID_BITS-1]) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				inc_q     <= s_tdata[128];
				d_q       <= d_in;
				b_q       <= BW'(ID_BITS - 1);
				res_loc_q <= 1'b0;
				res_lvl_q <= '0;
				if (cmd == pdt_pkg::CMD_TARGET && lvl_in <= TopLvl) begin
					res_status_q <= pdt_pkg::STAT_OK;
					res_id_q     <= (loc ^ tdist) & IdMask;
				end else begin
					res_status_q <= pdt_pkg::STAT_NONE;
					res_id_q     <= '0;
				end
			end
			ST_SCAN: begin
				if (tok_end.vld) begin
					case (tok_end.cmd)
						pdt_pkg::CMD_ADD: begin
							res_status_q <= tok_end.hit ? pdt_pkg::STAT_OK
								: pdt_pkg::STAT_FULL;
						end
						pdt_pkg::CMD_HAS: begin
							res_status_q <= tok_end.hit ? pdt_pkg::STAT_OK
								: pdt_pkg::STAT_NONE;
						end
						pdt_pkg::CMD_REMOVE: begin
							res_status_q <= tok_end.hit ? pdt_pkg::STAT_OK
								: pdt_pkg::STAT_NONE;
							res_id_q     <= tok_end.hit ? tok_end.pid : '0;
						end
						default: begin
							if (inc_q && (!tok_end.hit ||
									(tok_end.pid ^ loc) < tok_end.best_d)) begin
								res_status_q <= pdt_pkg::STAT_OK;
								res_id_q     <= loc;
								res_loc_q    <= 1'b1;
							end else if (tok_end.hit) begin
								res_status_q <= pdt_pkg::STAT_OK;
								res_id_q     <= tok_end.best;
							end
						end
					endcase
				end
			end
			ST_LVL: begin
				// The top set bit has reached the upper end when d_q[ID_BITS-1] is set.
				if (d_q[ID_BITS-1]) begin
					res_status_q <= pdt_pkg::STAT_OK;
					res_lvl_q    <= TopLvl - lvl;
				end else begin
					d_q <= d_q << 1;
					b_q <= b_q - BW'(1);
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {res_lvl_q, res_loc_q, res_id_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr == pdt_pkg::REG_LOCAL_ID) ? local_id_q : '0;

endmodule

@@ rtl/pdt_checker.sv @@
// Port-level checks for the XOR-distance peer table, bound to the top level.
// Depends on pdt_pkg.
module pdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// A result that is held back must stay offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// Only one item is in progress at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == pdt_pkg::STAT_OK || m_tuser == pdt_pkg::STAT_FULL ||
			m_tuser == pdt_pkg::STAT_NONE))
		else $error("unknown status code");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pdt_pkg::STAT_OK |-> m_tdata[64:0] == '0)
		else $error("failed item carries an id");

endmodule

bind xor_distance_peer_table pdt_checker u_pdt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
